[rtl/core/double_to_float_pair_split_macros.svh]
// Assertion macros for the pair split block.
`ifndef DOUBLE_TO_FLOAT_PAIR_SPLIT_MACROS_SVH
`define DOUBLE_TO_FLOAT_PAIR_SPLIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DFPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfps check failed");
// Next-cycle implication.
`define DFPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfps check failed");
`endif

[rtl/core/dfps_pkg.sv]
// ----------------------------------------------------------------------------
// dfps_pkg
// Shared types and constants for the binary64 to binary32 pair split.
// ----------------------------------------------------------------------------
package dfps_pkg;
	localparam logic [31:0] F32_INF  = 32'h7F80_0000;
	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

	// Split result of one part, before rounding.
	typedef struct packed {
		logic        zero;
		logic [5:0]  top;
		logic [52:0] mag;
	} part_t;

	// Per-item class carried along the pipe.
	typedef struct packed {
		logic        sign;
		logic        special;
		logic [31:0] hi_spec;
		logic [31:0] lo_spec;
		logic signed [12:0] e;
	} item_t;

	function automatic logic [5:0] msb_pos(input logic [52:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 53; i++)
			if (m[i]) p = 6'(i);
		return p;
	endfunction
endpackage

[rtl/core/dfps_round.sv]
// ----------------------------------------------------------------------------
// dfps_round
// Registered round-to-nearest-even of mag * 2^e to binary32 (two stages).
// ----------------------------------------------------------------------------
module dfps_round (
	input  logic               clk,
	input  logic               en,
	input  logic               sign,
	input  dfps_pkg::part_t    part,
	input  logic signed [12:0] e,
	output logic [31:0]        bits
);
	import dfps_pkg::*;

	logic signed [13:0] lsb_c, sh_c;
	logic signed [13:0] lsb_s1, sh_s1;
	logic [52:0] mag_s1;
	logic        zero_s1, sign_s1;
	logic [52:0] q_c, rest_c, half_c, mask_c;
	logic        up_c;
	logic [33:0] sum_c;
	logic [31:0] res_c;

	always_comb begin
		lsb_c = 14'(signed'({1'b0, part.top})) + 14'(e) - 14'sd23;
		if (lsb_c < -14'sd149) lsb_c = -14'sd149;
		sh_c = lsb_c - 14'(e);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lsb_s1  <= lsb_c;
			sh_s1   <= sh_c;
			mag_s1  <= part.mag;
			zero_s1 <= part.zero;
			sign_s1 <= sign;
		end
	end

	always_comb begin
		q_c = '0; rest_c = '0; half_c = '0; mask_c = '0; up_c = 1'b0;
		if (sh_s1 <= 0) begin
			q_c = mag_s1 << 6'(-sh_s1);
		end else if (sh_s1 < 14'sd54) begin
			mask_c = (53'(1) << 6'(sh_s1)) - 53'(1);
			rest_c = mag_s1 & mask_c;
			half_c = 53'(1) << 6'(sh_s1 - 14'sd1);
			q_c    = mag_s1 >> 6'(sh_s1);
			up_c   = (rest_c > half_c) || (rest_c == half_c && q_c[0]);
		end else begin
			q_c = '0;
		end
		sum_c = 34'(lsb_s1 + 14'sd149) << 23;
		sum_c = sum_c + 34'(q_c[24:0]) + 34'(up_c);
		if (zero_s1 || (sh_s1 >= 14'sd54)) res_c = {sign_s1, 31'd0};
		else if (sum_c >= 34'(F32_INF)) res_c = {sign_s1, F32_INF[30:0]};
		else res_c = {sign_s1, sum_c[30:0]};
	end

	always_ff @(posedge clk) begin
		if (en) bits <= res_c;
	end
endmodule

[rtl/core/dfps_split.sv]
// ----------------------------------------------------------------------------
// dfps_split
// Decode the binary64 input and split the significand at 2^SPLIT_EXPONENT.
// ----------------------------------------------------------------------------
module dfps_split #(
	parameter int SPLIT_EXPONENT = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [63:0]           value_bits,
	output dfps_pkg::item_t       item_s1,
	output dfps_pkg::part_t       hi_s1,
	output dfps_pkg::part_t       lo_s1
);
	import dfps_pkg::*;

	logic [10:0] ef;
	logic [51:0] fr;
	logic [52:0] sig, hi_m, lo_m;
	logic signed [12:0] e;
	logic signed [13:0] k;
	item_t it;

	always_comb begin
		ef  = value_bits[62:52];
		fr  = value_bits[51:0];
		sig = (ef == '0) ? {1'b0, fr} : {1'b1, fr};
		e   = (ef == '0) ? -13'sd1074 : 13'(signed'({2'b0, ef})) - 13'sd1075;
		k   = 14'(SPLIT_EXPONENT) - 14'(e);
		if (k <= 0) begin
			hi_m = sig; lo_m = '0;
		end else if (k >= 14'sd53) begin
			hi_m = '0; lo_m = sig;
		end else begin
			hi_m = (sig >> 6'(k)) << 6'(k);
			lo_m = sig - hi_m;
		end
		it.sign    = value_bits[63];
		it.e       = e;
		it.special = (ef == '1);
		if (fr == '0) begin
			it.hi_spec = {value_bits[63], F32_INF[30:0]};
			it.lo_spec = F32_QNAN;
		end else begin
			it.hi_spec = {value_bits[63], F32_QNAN[30:0]} | {10'd0, fr[50:29]};
			it.lo_spec = it.hi_spec;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= it;
			hi_s1   <= '{zero: hi_m == '0, top: msb_pos(hi_m), mag: hi_m};
			lo_s1   <= '{zero: lo_m == '0, top: msb_pos(lo_m), mag: lo_m};
		end
	end
endmodule

[rtl/core/double_to_float_pair_split.sv]
// ----------------------------------------------------------------------------
// Binary64 to binary32 high/low pair split.
// Input channel s_axis: one binary64 bit pattern per transfer on s_axis_tdata.
// Output channel m_axis: per input one transfer with the high part in
// bits 31:0 and the low remainder in bits 63:32 of m_axis_tdata.
// The high part is the magnitude truncated to a multiple of 2^SPLIT_EXPONENT,
// the low part the exact remainder, both rounded to nearest even.
// Four register stages: one split stage, two rounding stages, one output
// register. One item per cycle is sustained while m_axis_tready stays high;
// valid bits travel with the data. While m_axis_tvalid is high and
// m_axis_tready low the whole pipe holds; s_axis_tready is high whenever
// the output register is empty or being drained, so a stall loses and
// repeats nothing. Reset clears all valid bits; no data is held.
// ----------------------------------------------------------------------------
module double_to_float_pair_split #(
	parameter int SPLIT_EXPONENT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] value_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // [31:0] high_bits, [63:32] low_bits
);
	import dfps_pkg::*;
	`include "double_to_float_pair_split_macros.svh"

	logic   en;
	logic   v_s1, v_s2, v_s3;
	logic   lo_sign;
	item_t  item_s1, item_s2, item_s3;
	part_t  hi_s1, lo_s1;
	logic [31:0] hi_r, lo_r;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	// an exact zero remainder is +0 whatever the input sign
	assign lo_sign       = item_s1.sign && !lo_s1.zero;

	dfps_split #(.SPLIT_EXPONENT(SPLIT_EXPONENT)) u_split (
		.clk, .en, .value_bits(s_axis_tdata), .item_s1, .hi_s1, .lo_s1
	);

	dfps_round u_hi (.clk, .en, .sign(item_s1.sign), .part(hi_s1),
		.e(item_s1.e), .bits(hi_r));
	dfps_round u_lo (.clk, .en, .sign(lo_sign), .part(lo_s1),
		.e(item_s1.e), .bits(lo_r));

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			item_s3 <= item_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (item_s3.special) m_axis_tdata <= {item_s3.lo_spec, item_s3.hi_spec};
			else m_axis_tdata <= {lo_r, hi_r};
		end
	end

	`DFPS_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`DFPS_ASSERT_IMP(a_rdy, !m_axis_tvalid, s_axis_tready)
	`DFPS_ASSERT_NXT(a_adv, en && v_s3, m_axis_tvalid)
endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the binary64 to binary32 high/low split against an integer predictor
// over directed edge values and random patterns, with random stalls on both
// sides.
// ----------------------------------------------------------------------------
module tb;
	localparam int SPLIT_EXP = 16;
	localparam int WDOG_LIMIT = 2000;

	class split_scoreboard;
		logic [63:0] pending[$];
		int fails;

		function automatic logic [31:0] round_f32(logic sgn, logic [63:0] mag, int ex);
			int top, lsb, sh;
			logic [63:0] q, rest, half, bits;
			if (mag == 0) return {sgn, 31'b0};
			top = 0;
			while (top < 63 && (mag >> (top + 1)) != 0) top++;
			lsb = top + ex - 23;
			if (lsb < -149) lsb = -149;
			sh = lsb - ex;
			if (sh <= 0) begin
				q = mag << (-sh);
			end else if (sh >= 64) begin
				return {sgn, 31'b0};
			end else begin
				rest = mag & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				q = mag >> sh;
				if (rest > half || (rest == half && q[0])) q++;
			end
			bits = (64'(lsb + 149) << 23) + q;
			if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
			return {sgn, bits[30:0]};
		endfunction

		function automatic logic [63:0] split(logic [63:0] v);
			logic sgn;
			logic [10:0] ef;
			logic [51:0] fr;
			logic [63:0] sig, hm, rm;
			logic [31:0] hb, lb, nan;
			int ex, k;
			sgn = v[63];
			ef = v[62:52];
			fr = v[51:0];
			if (ef == 11'h7FF) begin
				if (fr == 0) return {dfps_pkg::F32_QNAN, sgn, dfps_pkg::F32_INF[30:0]};
				nan = {sgn, 31'h7FC0_0000} | {10'b0, fr[50:29]};
				return {nan, nan};
			end
			sig = (ef == 0) ? {12'b0, fr} : {11'b0, 1'b1, fr};
			ex = (ef == 0) ? -1074 : int'(ef) - 1075;
			k = SPLIT_EXP - ex;
			if (k <= 0) begin
				hm = sig; rm = 0;
			end else if (k >= 64) begin
				hm = 0; rm = sig;
			end else begin
				hm = (sig >> k) << k; rm = sig - hm;
			end
			hb = round_f32(sgn, hm, ex);
			lb = (rm == 0) ? 32'b0 : round_f32(sgn, rm, ex);
			return {lb, hb};
		endfunction

		function void note_input(logic [63:0] v);
			pending.push_back(split(v));
		endfunction

		function void check_result(logic [63:0] got);
			logic [63:0] exp_v;
			if (pending.size() == 0) begin
				$display("%0t: unexpected transfer %h", $time, got);
				fails++;
				return;
			end
			exp_v = pending.pop_front();
			if (got[31:0] !== exp_v[31:0]) begin
				$display("%0t: high_bits exp %h got %h", $time, exp_v[31:0], got[31:0]);
				fails++;
			end
			if (got[63:32] !== exp_v[63:32]) begin
				$display("%0t: low_bits exp %h got %h", $time, exp_v[63:32], got[63:32]);
				fails++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, m_axis_tready = 0;
	logic [63:0] s_axis_tdata = '0;
	logic s_axis_tready, m_axis_tvalid;
	logic [63:0] m_axis_tdata;
	int src_idle = 0, snk_idle = 0, wdog = 0;
	split_scoreboard sb = new();

	double_to_float_pair_split #(.SPLIT_EXPONENT(SPLIT_EXP)) u_top (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			m_axis_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if (wdog >= WDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_value(logic [63:0] v);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		logic [10:0] ef;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0: ef = 11'h7FF;
			1: ef = 11'h000;
			2, 3: ef = 11'(1023 + $urandom_range(0, 60) - 20);
			4: ef = 11'(1023 + 127 + $urandom_range(0, 4) - 2);
			5: ef = 11'(1023 - 149 + $urandom_range(0, 40) - 20);
			default: ef = v[62:52];
		endcase
		v[62:52] = ef;
		if ($urandom_range(7) == 0) v[15:0] = 0;
		return v;
	endfunction

	initial begin
		logic [63:0] directed[$];
		directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
			64'hBFF0_0000_0000_0000, 64'h40F0_0000_0000_0000, 64'h40F0_0001_0000_0000,
			64'hC0F0_0001_8000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
			64'h7FF8_0000_0000_0000, 64'hFFF7_FFFF_FFFF_FFFF, 64'h7FF0_0000_2000_0000,
			64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
			64'h800F_FFFF_FFFF_FFFF, 64'h47EF_FFFF_F000_0000, 64'h47EF_FFFF_E000_0000,
			64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0001, 64'h4330_0000_0000_0001,
			64'h42F0_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 8 : (ph == 1) ? 78 : 0;
			snk_idle = (ph == 0) ? 78 : (ph == 1) ? 8 : 0;
			if (ph == 0)
				foreach (directed[i]) send_value(directed[i]);
			repeat (250) send_value(rand_value());
		end
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
